/* src/pfde_pkg.sv */
`default_nettype none
package pfde_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int PAGE_ROWS         = 8;

  // Clipped coordinates cover screens up to 256 pixels on a side.
  localparam int COORD_W = 8;
  localparam int PAGE_W  = 5;
  // Raw corner arithmetic: x + w - 1 spans -513 .. 509.
  localparam int CRD_W   = 11;

  localparam logic [2:0] MODE_PIXEL   = 3'd0;
  localparam logic [2:0] MODE_OUTLINE = 3'd1;
  localparam logic [2:0] MODE_FILL    = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    JOB_SPAN  = 2'd0,
    JOB_CLEAR = 2'd1,
    JOB_READ  = 2'd2,
    JOB_NONE  = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic               last;
    logic               empty;
    logic               on;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] col_hi;
    logic [COORD_W-1:0] row_lo;
    logic [COORD_W-1:0] row_hi;
    logic [6:0]         rd_col;
    logic [2:0]         rd_page;
  } job_t;

endpackage
`default_nettype wire

/* src/pfde_if.sv */
`default_nettype none
interface pfde_cmd_if;
  import pfde_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [8:0] pos_x;
  logic signed [8:0] pos_y;
  logic signed [8:0] rect_width;
  logic signed [8:0] rect_height;
  logic              pixel_on;
  logic [6:0]        read_column;
  logic [2:0]        read_page;

  modport source (
    output valid, mode, pos_x, pos_y, rect_width, rect_height, pixel_on,
           read_column, read_page,
    input  ready
  );
  modport sink (
    input  valid, mode, pos_x, pos_y, rect_width, rect_height, pixel_on,
           read_column, read_page,
    output ready
  );
endinterface

interface pfde_res_if;
  import pfde_pkg::*;

  logic  valid;
  logic  ready;
  byte_t read_byte;

  modport source (output valid, read_byte, input ready);
  modport sink (input valid, read_byte, output ready);
endinterface
`default_nettype wire

/* src/pfde_ram.sv */
`default_nettype none
module pfde_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/pfde_queue.sv */
`default_nettype none
module pfde_queue #(
  parameter int DEPTH = pfde_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pfde_pkg::job_t push_job,
  output logic                push_ready,
  input  wire logic           pop,
  output logic                pop_valid,
  output pfde_pkg::job_t      pop_job
);
  import pfde_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

/* src/pfde_front.sv */
`default_nettype none
module pfde_front #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  pfde_cmd_if.sink       in_cmd,
  input  wire logic      clearing,
  output logic           q_push,
  output pfde_pkg::job_t q_job,
  input  wire logic      q_ready
);
  import pfde_pkg::*;

  localparam int PAGE_COUNT = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam logic signed [CRD_W-1:0] COL_MAX = CRD_W'(SCREEN_WIDTH - 1);
  localparam logic signed [CRD_W-1:0] ROW_MAX = CRD_W'(SCREEN_HEIGHT - 1);

  logic              busy_r, busy_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [2:0]        mode_r;
  logic signed [8:0] x_r, y_r, w_r, h_r;
  logic              on_r;
  logic [6:0]        rcol_r;
  logic [2:0]        rpage_r;

  logic signed [CRD_W-1:0] x, y, xw, yh;
  logic signed [CRD_W-1:0] c_lo, c_hi, r_lo, r_hi;
  logic [COORD_W-1:0]      c_lo_cl, c_hi_cl, r_lo_cl, r_hi_cl;
  logic                    c_empty, r_empty, rd_bad, last;
  logic                    accept;

  function automatic logic clip_empty(input logic signed [CRD_W-1:0] lo,
                                      input logic signed [CRD_W-1:0] hi,
                                      input logic signed [CRD_W-1:0] max);
    clip_empty = hi[CRD_W-1] || (lo > max) || (lo > hi);
  endfunction

  function automatic logic [COORD_W-1:0] clip(input logic signed [CRD_W-1:0] v,
                                              input logic signed [CRD_W-1:0] max);
    logic signed [CRD_W-1:0] t;
    t = v[CRD_W-1] ? '0 : ((v > max) ? max : v);
    clip = t[COORD_W-1:0];
  endfunction

  assign in_cmd.ready = !busy_r && !clearing;
  assign accept       = in_cmd.valid && in_cmd.ready;

  always_comb begin
    x  = {{(CRD_W-9){x_r[8]}}, x_r};
    y  = {{(CRD_W-9){y_r[8]}}, y_r};
    xw = x + {{(CRD_W-9){w_r[8]}}, w_r} - CRD_W'(1);
    yh = y + {{(CRD_W-9){h_r[8]}}, h_r} - CRD_W'(1);

    c_lo = x;
    c_hi = x;
    r_lo = y;
    r_hi = y;
    case (mode_r)
      MODE_OUTLINE: begin
        // two row lines, then two column lines
        case (k_r)
          2'd0: begin
            c_hi = xw;
          end
          2'd1: begin
            c_hi = xw;
            r_lo = yh;
            r_hi = yh;
          end
          2'd2: begin
            r_hi = yh;
          end
          default: begin
            c_lo = xw;
            c_hi = xw;
            r_hi = yh;
          end
        endcase
      end
      MODE_FILL: begin
        c_hi = xw;
        r_hi = yh;
      end
      default: begin
      end
    endcase

    c_empty = clip_empty(c_lo, c_hi, COL_MAX);
    r_empty = clip_empty(r_lo, r_hi, ROW_MAX);
    c_lo_cl = clip(c_lo, COL_MAX);
    c_hi_cl = clip(c_hi, COL_MAX);
    r_lo_cl = clip(r_lo, ROW_MAX);
    r_hi_cl = clip(r_hi, ROW_MAX);
    rd_bad  = (9'(rcol_r) >= 9'(SCREEN_WIDTH)) || (6'(rpage_r) >= 6'(PAGE_COUNT));
    last    = (mode_r == MODE_OUTLINE) ? (k_r == 2'd3) : 1'b1;

    q_job.last    = last;
    q_job.on      = on_r;
    q_job.col_lo  = c_lo_cl;
    q_job.col_hi  = c_hi_cl;
    q_job.row_lo  = r_lo_cl;
    q_job.row_hi  = r_hi_cl;
    q_job.rd_col  = rcol_r;
    q_job.rd_page = rpage_r;
    case (mode_r)
      MODE_PIXEL, MODE_OUTLINE, MODE_FILL: begin
        q_job.kind  = JOB_SPAN;
        q_job.empty = c_empty || r_empty;
      end
      MODE_CLEAR: begin
        q_job.kind  = JOB_CLEAR;
        q_job.empty = 1'b0;
      end
      MODE_READ: begin
        q_job.kind  = JOB_READ;
        q_job.empty = rd_bad;
      end
      default: begin
        q_job.kind  = JOB_NONE;
        q_job.empty = 1'b0;
      end
    endcase
  end

  assign q_push = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (accept) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (busy_r && q_ready) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_cmd.mode;
      x_r     <= in_cmd.pos_x;
      y_r     <= in_cmd.pos_y;
      w_r     <= in_cmd.rect_width;
      h_r     <= in_cmd.rect_height;
      on_r    <= in_cmd.pixel_on;
      rcol_r  <= in_cmd.read_column;
      rpage_r <= in_cmd.read_page;
    end
  end

endmodule
`default_nettype wire

/* src/pfde_back.sv */
`default_nettype none
module pfde_back #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF,
  parameter int ADDR_W        = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire pfde_pkg::job_t      q_job,
  output logic                     q_pop,
  output logic                     ram_we,
  output logic [ADDR_W-1:0]        ram_waddr,
  output pfde_pkg::byte_t          ram_wdata,
  output logic [ADDR_W-1:0]        ram_raddr,
  input  wire pfde_pkg::byte_t     ram_rdata,
  output logic                     clearing,
  pfde_res_if.source               out_res
);
  import pfde_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0] SW_A      = ADDR_W'(SCREEN_WIDTH);

  typedef enum logic [5:0] {
    ST_CLR   = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_RDW   = 6'b010000,
    ST_FIN   = 6'b100000
  } st_t;

  st_t                state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [COORD_W-1:0] c_r, c_nxt;
  logic [PAGE_W-1:0]  p_r, p_nxt;
  logic               wv_r, wv_nxt;
  logic [ADDR_W-1:0]  wa_r, wa_nxt;
  byte_t              wm_r, wm_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  byte_t              res_r, res_nxt;
  logic               ov_r, ov_nxt;
  byte_t              ob_r, ob_nxt;

  logic [PAGE_W-1:0]  pg_lo, pg_hi;
  logic [2:0]         lo_bit, hi_bit;
  byte_t              mask;
  logic [ADDR_W-1:0]  run_addr;

  function automatic logic [ADDR_W-1:0] fb_addr(input logic [COORD_W-1:0] col,
                                                input logic [PAGE_W-1:0] pg);
    fb_addr = ADDR_W'(pg) * SW_A + ADDR_W'(col);
  endfunction

  assign clearing      = (state_r == ST_CLR);
  assign out_res.valid     = ov_r;
  assign out_res.read_byte = ob_r;

  always_comb begin
    pg_lo    = PAGE_W'(job_r.row_lo[COORD_W-1:3]);
    pg_hi    = PAGE_W'(job_r.row_hi[COORD_W-1:3]);
    lo_bit   = (p_r == pg_lo) ? job_r.row_lo[2:0] : 3'd0;
    hi_bit   = (p_r == pg_hi) ? job_r.row_hi[2:0] : 3'd7;
    mask     = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
    run_addr = fb_addr(c_r, p_r);
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    c_nxt     = c_r;
    p_nxt     = p_r;
    wv_nxt    = wv_r;
    wa_nxt    = wa_r;
    wm_nxt    = wm_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && !out_res.ready;
    ob_nxt    = ob_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = job_r.on ? (ram_rdata | wm_r) : (ram_rdata & ~wm_r);
    ram_raddr = run_addr;

    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_FIN;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        ram_raddr = fb_addr(COORD_W'(q_job.rd_col), PAGE_W'(q_job.rd_page));
        if (q_valid) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          c_nxt   = q_job.col_lo;
          p_nxt   = PAGE_W'(q_job.row_lo[COORD_W-1:3]);
          wv_nxt  = 1'b0;
          res_nxt = '0;
          clr_nxt = '0;
          case (q_job.kind)
            JOB_SPAN:  state_nxt = q_job.empty ? ST_FIN : ST_RUN;
            JOB_CLEAR: state_nxt = ST_CLR;
            JOB_READ:  state_nxt = q_job.empty ? ST_FIN : ST_RDW;
            default:   state_nxt = ST_FIN;
          endcase
        end
      end
      ST_RUN: begin
        // read this byte, write back the one read last cycle
        ram_we = wv_r;
        wv_nxt = 1'b1;
        wa_nxt = run_addr;
        wm_nxt = mask;
        if (p_r == pg_hi) begin
          p_nxt = pg_lo;
          if (c_r == job_r.col_hi) begin
            state_nxt = ST_DRAIN;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        ram_we    = 1'b1;
        wv_nxt    = 1'b0;
        state_nxt = ST_FIN;
      end
      ST_RDW: begin
        res_nxt   = ram_rdata;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!job_r.last) begin
          state_nxt = ST_IDLE;
        end else if (!ov_r || out_res.ready) begin
          ov_nxt    = 1'b1;
          ob_nxt    = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      job_r   <= '0;
      clr_r   <= '0;
      wv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      clr_r   <= clr_nxt;
      wv_r    <= wv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    p_r   <= p_nxt;
    wa_r  <= wa_nxt;
    wm_r  <= wm_nxt;
    res_r <= res_nxt;
    ob_r  <= ob_nxt;
  end

endmodule
`default_nettype wire

/* src/page_framebuffer_draw_engine_unit.sv */
`default_nettype none
// Results: out_res.valid rises once the last job of an accepted command finishes; this holds
// for pixel and read commands (also when clipped or off the screen) as for every other mode.
// Throughput: fills and outlines handle one touched page byte per cycle, each span adding
// the idle, drain and finish states (an outline is four spans); clear-all sweeps all
// SCREEN_WIDTH * pages bytes. Reset: synchronous, active low; afterwards the frame RAM is swept
// to zero, one byte a cycle (1024 bytes at 128x64), and no command is accepted until the sweep ends.
module page_framebuffer_draw_engine_unit #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF,
  parameter int QUEUE_DEPTH   = pfde_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pfde_cmd_if.sink  in_cmd,
  pfde_res_if.source out_res
);
  import pfde_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic              clearing;
  logic              push, push_ready, pop, pop_valid;
  job_t              push_job, pop_job;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  byte_t             ram_wdata, ram_rdata;

  pfde_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (in_cmd),
    .clearing (clearing),
    .q_push   (push),
    .q_job    (push_job),
    .q_ready  (push_ready)
  );

  pfde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job)
  );

  pfde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_job     (pop_job),
    .q_pop     (pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .clearing  (clearing),
    .out_res   (out_res)
  );

  pfde_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
